>>> src/assert_macros.svh
// Assertion helpers used by the renderer RTL. Each use stands on a line of its own
// and carries its own trailing semicolon.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BTC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define BTC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> src/btc_pkg.sv
package btc_pkg;

    // Field and storage widths fixed by the interface.
    localparam int CURSOR_W  = 26;
    localparam int CHAR_W    = 8;
    localparam int ROW_W     = 3;
    localparam int COL_W     = 3;
    localparam int FONT_DW   = 8;
    localparam int FONT_AW   = CHAR_W + ROW_W;
    localparam int FONT_DEPTH = 1 << FONT_AW;
    localparam int PITCH_W   = 15;
    localparam int BPP_W     = 3;
    localparam int ADDR_W    = 32;
    localparam int COLOR_W   = 32;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DW    = 32;

    // Cursor plus one glyph advance needs one bit more than the cursor.
    localparam int DVD_W  = CURSOR_W + 1;
    // Glyph advance in bytes: up to 8 pixels of up to 7 bytes.
    localparam int STEP_W = 6;
    // Up to 8 scanlines of pitch.
    localparam int SPAN_W = 18;

    localparam int DEF_GLYPH_WIDTH  = 8;
    localparam int DEF_GLYPH_HEIGHT = 8;

    // Configuration reset values.
    localparam logic                RST_SCREEN_ON  = 1'b1;
    localparam logic [ADDR_W-1:0]   RST_FRAME_BASE = '0;
    localparam logic [BPP_W-1:0]    RST_BPP        = 3'd4;
    localparam logic [PITCH_W-1:0]  RST_PITCH      = 15'd4096;
    localparam logic [CURSOR_W-1:0] RST_WINDOW     = 26'd3145728;

    // Special character codes.
    localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR  = 8'h0D;

    typedef enum logic [OP_W-1:0] {
        OP_DRAW       = 2'd0,
        OP_SET_CURSOR = 2'd1,
        OP_FONT_LOAD  = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_ON  = 3'd0,
        CFG_FRAME_BASE = 3'd1,
        CFG_BPP        = 3'd2,
        CFG_PITCH      = 3'd3,
        CFG_WINDOW     = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        KIND_GLYPH,
        KIND_NEWLINE,
        KIND_RETURN
    } t_kind;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
    } t_pix;

    typedef struct packed {
        logic push;
        logic flush;
    } t_emit_ctrl;

    typedef struct packed {
        logic take_ok;
        logic pend_valid;
    } t_emit_stat;

endpackage

>>> src/btc_font_mem.sv
module btc_font_mem (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [btc_pkg::FONT_AW-1:0]  i_wr_addr,
    input  logic [btc_pkg::FONT_DW-1:0]  i_wr_data,
    input  logic                         i_rd_en,
    input  logic [btc_pkg::FONT_AW-1:0]  i_rd_addr,
    output logic [btc_pkg::FONT_DW-1:0]  o_rd_data
);

    logic [btc_pkg::FONT_DW-1:0] r_mem [btc_pkg::FONT_DEPTH];
    logic [btc_pkg::FONT_DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds until the next read, so a stalled scan keeps its row.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/btc_rem_div.sv
module btc_rem_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [btc_pkg::DVD_W-1:0]    i_dividend,
    input  logic [btc_pkg::PITCH_W-1:0]  i_divisor,
    output logic                         o_busy,
    output logic [btc_pkg::PITCH_W-1:0]  o_rem
);

    localparam int CNT_W = $clog2(btc_pkg::DVD_W + 1);

    logic                         r_busy;
    logic [CNT_W-1:0]             r_cnt;
    logic [btc_pkg::DVD_W-1:0]    r_dvd;
    logic [btc_pkg::PITCH_W-1:0]  r_div;
    logic [btc_pkg::PITCH_W-1:0]  r_rem;

    logic [btc_pkg::PITCH_W:0]    w_trial;
    logic [btc_pkg::PITCH_W:0]    w_diff;
    logic                         w_fits;
    logic [btc_pkg::PITCH_W-1:0]  n_rem;

    // Restoring remainder, one dividend bit per cycle, MSB first.
    assign w_trial = {r_rem, r_dvd[btc_pkg::DVD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_fits  = w_trial >= {1'b0, r_div};
    assign n_rem   = w_fits ? w_diff[btc_pkg::PITCH_W-1:0] : w_trial[btc_pkg::PITCH_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(btc_pkg::DVD_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[btc_pkg::DVD_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;

endmodule

>>> src/btc_pix_out.sv
module btc_pix_out (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  btc_pkg::t_emit_ctrl  i_ctrl,
    input  btc_pkg::t_pix        i_pix,
    output btc_pkg::t_emit_stat  o_stat,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output btc_pkg::t_pix        o_pix,
    output logic                 o_last
);

    logic           r_out_valid;
    logic           r_pend_valid;
    btc_pkg::t_pix  r_out_pix;
    btc_pkg::t_pix  r_pend_pix;
    logic           r_out_last;

    logic w_out_free;
    logic w_take_ok;
    logic w_push;
    logic w_flush;
    logic w_move;

    // A pixel waits in the pending stage until either a later pixel of the
    // same glyph arrives (so it is not the last) or the glyph ends.
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_take_ok  = !r_pend_valid || w_out_free;
    assign w_push     = i_ctrl.push && w_take_ok;
    assign w_flush    = i_ctrl.flush && r_pend_valid && w_out_free;
    assign w_move     = (w_push && r_pend_valid) || w_flush;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_push) begin
                r_pend_valid <= 1'b1;
            end else if (w_flush) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_pix  <= r_pend_pix;
            r_out_last <= w_flush;
        end
        if (w_push) begin
            r_pend_pix <= i_pix;
        end
    end

    assign o_stat.take_ok    = w_take_ok;
    assign o_stat.pend_valid = r_pend_valid;
    assign o_out_valid       = r_out_valid;
    assign o_pix             = r_out_pix;
    assign o_last            = r_out_last;

endmodule

>>> src/bitmap_text_console_renderer.sv
// Text console glyph renderer. Font rows are loaded one byte per transfer
// (op 2) into a 2048-entry font memory; op 1 sets the byte-offset cursor;
// op 0 draws one character at the cursor and produces one pixel-write
// transfer per drawn pixel, row by row and left to right, then advances the
// cursor (dropping a text row at the end of a scanline and wrapping to zero
// at the bottom of the window). A zero background is transparent, so clear
// font bits then produce no transfer. Newline and carriage return only move
// the cursor; NUL and draws while the screen is off do nothing. Cursor set,
// font load and ignored items are taken without leaving the idle state. A
// drawn character is scanned pixel by pixel, then the pending stage that
// marks the final pixel is drained and the cursor is updated before the next
// input transfer is taken. While the output does not stall, the scan handles
// one pixel per cycle, a rate set by the single font memory read port and
// that one-deep pending stage. The line-end test needs the advanced cursor
// modulo the pitch, which a bit-serial remainder unit finds alongside the
// pixel scan; newline and carriage return wait on that unit. A stalled
// output can hold the scan. Configuration transfers are always taken and
// must only happen while the block is idle.
`include "assert_macros.svh"

module bitmap_text_console_renderer #(
    parameter int GLYPH_WIDTH  = btc_pkg::DEF_GLYPH_WIDTH,
    parameter int GLYPH_HEIGHT = btc_pkg::DEF_GLYPH_HEIGHT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [btc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [btc_pkg::CFG_DW-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [btc_pkg::OP_W-1:0]       i_op,
    input  logic [btc_pkg::CHAR_W-1:0]     i_char_code,
    input  logic [btc_pkg::ROW_W-1:0]      i_glyph_row,
    input  logic [btc_pkg::FONT_DW-1:0]    i_font_bits,
    input  logic [btc_pkg::COLOR_W-1:0]    i_fg_color,
    input  logic [btc_pkg::COLOR_W-1:0]    i_bg_color,
    input  logic [btc_pkg::CURSOR_W-1:0]   i_cursor_value,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [btc_pkg::ADDR_W-1:0]     o_pixel_address,
    output logic [btc_pkg::COLOR_W-1:0]    o_pixel_color,
    output logic                           o_last_pixel
);

    // Configuration registers.
    logic                           r_screen_on;
    logic [btc_pkg::ADDR_W-1:0]     r_frame_base;
    logic [btc_pkg::BPP_W-1:0]      r_bpp;
    logic [btc_pkg::PITCH_W-1:0]    r_bpl;
    logic [btc_pkg::CURSOR_W-1:0]   r_window;

    // Control state.
    btc_pkg::t_state                r_state;
    btc_pkg::t_state                n_state;
    btc_pkg::t_kind                 r_kind;
    logic [btc_pkg::CURSOR_W-1:0]   r_cursor;
    logic [btc_pkg::CURSOR_W-1:0]   n_cursor;
    logic [btc_pkg::ROW_W-1:0]      r_row;
    logic [btc_pkg::COL_W-1:0]      r_col;

    // Per-character working registers.
    logic [btc_pkg::CHAR_W-1:0]     r_char;
    logic [btc_pkg::COLOR_W-1:0]    r_fg;
    logic [btc_pkg::COLOR_W-1:0]    r_bg;
    logic                           r_bg_on;
    logic [btc_pkg::STEP_W-1:0]     r_step;
    logic [btc_pkg::SPAN_W-1:0]     r_hp;
    logic [btc_pkg::SPAN_W-1:0]     r_h1p;
    logic [btc_pkg::ADDR_W-1:0]     r_row_addr;
    logic [btc_pkg::ADDR_W-1:0]     r_pix_addr;

    logic                           w_in_accept;
    logic                           w_is_draw;
    logic                           w_is_ctl_char;
    logic [btc_pkg::PITCH_W-1:0]    w_pitch;
    logic [btc_pkg::STEP_W-1:0]     w_step;
    logic [btc_pkg::ADDR_W-1:0]     w_start_addr;

    logic                           w_wr_en;
    logic [btc_pkg::FONT_AW-1:0]    w_wr_addr;
    logic                           w_rd_en;
    logic [btc_pkg::FONT_AW-1:0]    w_rd_addr;
    logic [btc_pkg::FONT_DW-1:0]    w_rd_data;

    logic                           w_bit;
    logic                           w_emit;
    logic                           w_last_col;
    logic                           w_last_row;
    logic                           w_adv;
    logic [btc_pkg::ADDR_W-1:0]     w_next_row_addr;

    logic                           w_div_start;
    logic [btc_pkg::DVD_W-1:0]      w_dividend;
    logic                           w_div_busy;
    logic [btc_pkg::PITCH_W-1:0]    w_rem;

    logic [btc_pkg::DVD_W-1:0]      w_adv_cur;
    logic [btc_pkg::DVD_W:0]        w_drop_cur;
    logic [btc_pkg::DVD_W+1:0]      w_drop_end;
    logic [btc_pkg::CURSOR_W-1:0]   w_line_start;
    logic [btc_pkg::DVD_W-1:0]      w_nl_cur;
    logic                           w_finish;

    btc_pkg::t_emit_ctrl            w_ctrl;
    btc_pkg::t_emit_stat            w_stat;
    btc_pkg::t_pix                  w_pix;
    btc_pkg::t_pix                  w_out_pix;

    // ------------------------------------------------------------------
    // Configuration port: always ready, one register per transfer.
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_on  <= btc_pkg::RST_SCREEN_ON;
            r_frame_base <= btc_pkg::RST_FRAME_BASE;
            r_bpp        <= btc_pkg::RST_BPP;
            r_bpl        <= btc_pkg::RST_PITCH;
            r_window     <= btc_pkg::RST_WINDOW;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                btc_pkg::CFG_SCREEN_ON:  r_screen_on  <= i_cfg_data[0];
                btc_pkg::CFG_FRAME_BASE: r_frame_base <= i_cfg_data;
                btc_pkg::CFG_BPP:        r_bpp        <= i_cfg_data[btc_pkg::BPP_W-1:0];
                btc_pkg::CFG_PITCH:      r_bpl        <= i_cfg_data[btc_pkg::PITCH_W-1:0];
                btc_pkg::CFG_WINDOW:     r_window     <= i_cfg_data[btc_pkg::CURSOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A zero pitch behaves as a pitch of one byte.
    assign w_pitch = (r_bpl == '0) ? btc_pkg::PITCH_W'(1) : r_bpl;
    assign w_step  = btc_pkg::STEP_W'(GLYPH_WIDTH) * {3'b000, r_bpp};

    // ------------------------------------------------------------------
    // Input decode.
    // ------------------------------------------------------------------
    assign w_in_accept   = i_in_valid && o_in_ready;
    assign w_is_draw     = (i_op == btc_pkg::OP_DRAW) && r_screen_on
                           && (i_char_code != btc_pkg::CHAR_NUL);
    assign w_is_ctl_char = (i_char_code == btc_pkg::CHAR_LF)
                           || (i_char_code == btc_pkg::CHAR_CR);
    assign w_start_addr  = r_frame_base + {6'd0, r_cursor};

    // ------------------------------------------------------------------
    // Font memory. Row 0 is fetched in the transfer cycle; each following
    // row is fetched as the scan leaves the last column of the row before.
    // ------------------------------------------------------------------
    assign w_wr_en   = w_in_accept && (i_op == btc_pkg::OP_FONT_LOAD);
    assign w_wr_addr = {i_char_code, i_glyph_row};
    assign w_rd_en   = (w_in_accept && w_is_draw && !w_is_ctl_char)
                       || (w_adv && w_last_col && !w_last_row);
    assign w_rd_addr = w_in_accept ? {i_char_code, btc_pkg::ROW_W'(0)}
                                   : {r_char, r_row + 1'b1};

    btc_font_mem u_font_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (i_font_bits),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // ------------------------------------------------------------------
    // Pixel scan: one candidate pixel per cycle unless the output stalls,
    // leftmost pixel from the MSB of the font row. A clear bit with a
    // transparent background is skipped without a transfer.
    // ------------------------------------------------------------------
    assign w_bit      = w_rd_data[btc_pkg::COL_W'(btc_pkg::FONT_DW - 1) - r_col];
    assign w_emit     = w_bit || r_bg_on;
    assign w_last_col = (r_col == btc_pkg::COL_W'(GLYPH_WIDTH - 1));
    assign w_last_row = (r_row == btc_pkg::ROW_W'(GLYPH_HEIGHT - 1));
    assign w_adv      = (r_state == btc_pkg::ST_SCAN) && (!w_emit || w_stat.take_ok);
    assign w_next_row_addr = r_row_addr + {17'd0, w_pitch};

    assign w_pix.addr  = r_pix_addr;
    assign w_pix.color = w_bit ? r_fg : r_bg;

    btc_pix_out u_pix_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_pix       (w_pix),
        .o_stat      (w_stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_pix       (w_out_pix),
        .o_last      (o_last_pixel)
    );

    assign o_pixel_address = w_out_pix.addr;
    assign o_pixel_color   = w_out_pix.color;

    // ------------------------------------------------------------------
    // Remainder unit: advanced cursor modulo pitch for a glyph, current
    // cursor modulo pitch for newline and carriage return.
    // ------------------------------------------------------------------
    assign w_div_start = w_in_accept && w_is_draw;
    assign w_dividend  = w_is_ctl_char ? {1'b0, r_cursor}
                                       : {1'b0, r_cursor} + btc_pkg::DVD_W'(w_step);

    btc_rem_div u_rem_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_pitch),
        .o_busy     (w_div_busy),
        .o_rem      (w_rem)
    );

    // ------------------------------------------------------------------
    // Cursor update once the remainder is known.
    // ------------------------------------------------------------------
    assign w_adv_cur    = {1'b0, r_cursor} + btc_pkg::DVD_W'(r_step);
    assign w_drop_cur   = {1'b0, w_adv_cur} + (btc_pkg::DVD_W + 1)'(r_h1p);
    assign w_drop_end   = {1'b0, w_drop_cur} + (btc_pkg::DVD_W + 2)'(r_hp);
    assign w_line_start = r_cursor - btc_pkg::CURSOR_W'(w_rem);
    assign w_nl_cur     = {1'b0, w_line_start} + btc_pkg::DVD_W'(r_hp);
    assign w_finish     = (r_state == btc_pkg::ST_FINISH) && !w_div_busy;

    always_comb begin
        n_cursor = r_cursor;
        case (r_kind)
            btc_pkg::KIND_GLYPH: begin
                if (w_rem != '0) begin
                    n_cursor = w_adv_cur[btc_pkg::CURSOR_W-1:0];
                end else if (w_drop_end >= (btc_pkg::DVD_W + 2)'(r_window)) begin
                    n_cursor = '0;
                end else begin
                    n_cursor = w_drop_cur[btc_pkg::CURSOR_W-1:0];
                end
            end
            btc_pkg::KIND_NEWLINE: begin
                if (w_nl_cur >= btc_pkg::DVD_W'(r_window)) begin
                    n_cursor = '0;
                end else begin
                    n_cursor = w_nl_cur[btc_pkg::CURSOR_W-1:0];
                end
            end
            btc_pkg::KIND_RETURN: begin
                n_cursor = w_line_start;
            end
            default: begin
                n_cursor = r_cursor;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
        end else if (w_in_accept && (i_op == btc_pkg::OP_SET_CURSOR)) begin
            r_cursor <= i_cursor_value;
        end else if (w_finish) begin
            r_cursor <= n_cursor;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            btc_pkg::ST_IDLE: begin
                if (w_in_accept && w_is_draw) begin
                    n_state = w_is_ctl_char ? btc_pkg::ST_FINISH : btc_pkg::ST_SCAN;
                end
            end
            btc_pkg::ST_SCAN: begin
                if (w_adv && w_last_col && w_last_row) begin
                    n_state = btc_pkg::ST_FLUSH;
                end
            end
            btc_pkg::ST_FLUSH: begin
                if (!w_stat.pend_valid) begin
                    n_state = btc_pkg::ST_FINISH;
                end
            end
            btc_pkg::ST_FINISH: begin
                if (!w_div_busy) begin
                    n_state = btc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = btc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready   = (r_state == btc_pkg::ST_IDLE);
        w_ctrl.push  = (r_state == btc_pkg::ST_SCAN) && w_emit;
        w_ctrl.flush = (r_state == btc_pkg::ST_FLUSH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= btc_pkg::ST_IDLE;
            r_kind  <= btc_pkg::KIND_GLYPH;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            if (w_in_accept) begin
                r_row <= '0;
                r_col <= '0;
                if (i_char_code == btc_pkg::CHAR_LF) begin
                    r_kind <= btc_pkg::KIND_NEWLINE;
                end else if (i_char_code == btc_pkg::CHAR_CR) begin
                    r_kind <= btc_pkg::KIND_RETURN;
                end else begin
                    r_kind <= btc_pkg::KIND_GLYPH;
                end
            end else if (w_adv) begin
                if (w_last_col) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    // Per-character payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_char     <= i_char_code;
            r_fg       <= i_fg_color;
            r_bg       <= i_bg_color;
            r_bg_on    <= (i_bg_color != '0);
            r_step     <= w_step;
            r_hp       <= btc_pkg::SPAN_W'(GLYPH_HEIGHT) * {3'b000, w_pitch};
            r_h1p      <= btc_pkg::SPAN_W'(GLYPH_HEIGHT - 1) * {3'b000, w_pitch};
            r_row_addr <= w_start_addr;
            r_pix_addr <= w_start_addr;
        end else if (w_adv) begin
            if (w_last_col) begin
                r_row_addr <= w_next_row_addr;
                r_pix_addr <= w_next_row_addr;
            end else begin
                r_pix_addr <= r_pix_addr + {29'd0, r_bpp};
            end
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // The font memory is only loaded while idle, never during a scan read.
    `BTC_ASSERT_IMP(a_font_no_rw, i_clk, i_rst_n, w_rd_en, !w_wr_en)
    // The remainder unit always finishes before the sequencer returns idle.
    `BTC_ASSERT_IMP(a_div_idle, i_clk, i_rst_n, r_state == btc_pkg::ST_IDLE, !w_div_busy)
    // The final pixel has left the pending stage before the cursor moves.
    `BTC_ASSERT_IMP(a_flush_done, i_clk, i_rst_n, r_state == btc_pkg::ST_FINISH, !w_stat.pend_valid)
    // The cursor moves only on a set-cursor transfer or at the end of a draw.
    `BTC_ASSERT_NXT(a_cursor_hold, i_clk, i_rst_n, !w_in_accept && !w_finish, $stable(r_cursor))

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

// Regression for the text console glyph renderer. Font rows, cursor moves and
// character draws are pushed through the input channel while an independent
// model of the renderer, kept inside pixel_write_tracker, works out the pixel
// writes each accepted transfer should cause. Every pixel write seen on the
// output channel is checked in order against those predictions.
module testbench;

    localparam int GLYPH_W = btc_pkg::DEF_GLYPH_WIDTH;
    localparam int GLYPH_H = btc_pkg::DEF_GLYPH_HEIGHT;
    // The op field has one code the block must ignore.
    localparam logic [btc_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    // Covers work that is still going on after the last expected pixel write
    // has shown up.
    localparam int DRAIN_CYCLES = 150;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [btc_pkg::CFG_IDX_W-1:0]   i_cfg_index;
    logic [btc_pkg::CFG_DW-1:0]      i_cfg_data;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic [btc_pkg::OP_W-1:0]        i_op;
    logic [btc_pkg::CHAR_W-1:0]      i_char_code;
    logic [btc_pkg::ROW_W-1:0]       i_glyph_row;
    logic [btc_pkg::FONT_DW-1:0]     i_font_bits;
    logic [btc_pkg::COLOR_W-1:0]     i_fg_color;
    logic [btc_pkg::COLOR_W-1:0]     i_bg_color;
    logic [btc_pkg::CURSOR_W-1:0]    i_cursor_value;
    logic                            o_out_valid;
    logic                            i_out_ready;
    logic [btc_pkg::ADDR_W-1:0]      o_pixel_address;
    logic [btc_pkg::COLOR_W-1:0]     o_pixel_color;
    logic                            o_last_pixel;

    typedef struct {
        logic [btc_pkg::OP_W-1:0]     op;
        logic [btc_pkg::CHAR_W-1:0]   char_code;
        logic [btc_pkg::ROW_W-1:0]    glyph_row;
        logic [btc_pkg::FONT_DW-1:0]  font_bits;
        logic [btc_pkg::COLOR_W-1:0]  fg_color;
        logic [btc_pkg::COLOR_W-1:0]  bg_color;
        logic [btc_pkg::CURSOR_W-1:0] cursor_value;
    } t_console_item;

    typedef struct {
        logic [btc_pkg::ADDR_W-1:0]  address;
        logic [btc_pkg::COLOR_W-1:0] color;
        logic                        last;
    } t_pixel_write;

    // Holds its own copy of the renderer state and the pixel writes that are
    // still owed by transfers already taken.
    class pixel_write_tracker;
        t_pixel_write   awaited_pixels[$];
        bit             screen_on;
        bit [31:0]      frame_base;
        bit [2:0]       bytes_per_pixel;
        bit [14:0]      bytes_per_line;
        bit [25:0]      window_size;
        bit [25:0]      cursor;
        bit [7:0]       font_mem [2048];
        int             errors;
        int             glyphs_drawn;
        int             pixels_seen;

        function new();
            screen_on       = btc_pkg::RST_SCREEN_ON;
            frame_base      = btc_pkg::RST_FRAME_BASE;
            bytes_per_pixel = btc_pkg::RST_BPP;
            bytes_per_line  = btc_pkg::RST_PITCH;
            window_size     = btc_pkg::RST_WINDOW;
            cursor          = '0;
            foreach (font_mem[i]) font_mem[i] = '0;
            errors       = 0;
            glyphs_drawn = 0;
            pixels_seen  = 0;
        endfunction

        function void note_config(logic [btc_pkg::CFG_IDX_W-1:0] index,
                                  logic [btc_pkg::CFG_DW-1:0] data);
            case (index)
                btc_pkg::CFG_SCREEN_ON:  screen_on       = data[0];
                btc_pkg::CFG_FRAME_BASE: frame_base      = data;
                btc_pkg::CFG_BPP:        bytes_per_pixel = data[2:0];
                btc_pkg::CFG_PITCH:      bytes_per_line  = data[14:0];
                btc_pkg::CFG_WINDOW:     window_size     = data[25:0];
                default: ;
            endcase
        endfunction

        function void note_item(t_console_item it);
            longint unsigned pitch;
            longint unsigned cur;
            longint unsigned nxt;
            longint unsigned addr;
            int              total;
            int              emitted;
            bit [7:0]        row_bits;
            bit              lit;
            t_pixel_write    px;

            // A zero pitch behaves as a pitch of one byte.
            pitch = (bytes_per_line == 0) ? 1 : bytes_per_line;
            cur   = cursor;
            case (it.op)
                btc_pkg::OP_SET_CURSOR: cursor = it.cursor_value;
                btc_pkg::OP_FONT_LOAD:  font_mem[{it.char_code, it.glyph_row}] = it.font_bits;
                btc_pkg::OP_DRAW: begin
                    if (screen_on && it.char_code != btc_pkg::CHAR_NUL) begin
                        if (it.char_code == btc_pkg::CHAR_LF) begin
                            nxt = (cur / pitch + GLYPH_H) * pitch;
                            if (nxt >= window_size) nxt = 0;
                            cursor = nxt[25:0];
                        end else if (it.char_code == btc_pkg::CHAR_CR) begin
                            nxt = (cur / pitch) * pitch;
                            cursor = nxt[25:0];
                        end else begin
                            // Count first so the final write can carry the last flag.
                            total = 0;
                            for (int j = 0; j < GLYPH_H; j++) begin
                                row_bits = font_mem[{it.char_code, 3'(j)}];
                                for (int k = 0; k < GLYPH_W; k++) begin
                                    if (row_bits[7-k] || it.bg_color != 0) total++;
                                end
                            end
                            emitted = 0;
                            for (int j = 0; j < GLYPH_H; j++) begin
                                row_bits = font_mem[{it.char_code, 3'(j)}];
                                for (int k = 0; k < GLYPH_W; k++) begin
                                    lit = row_bits[7-k];
                                    if (lit || it.bg_color != 0) begin
                                        emitted++;
                                        addr = frame_base + cur + j * pitch
                                            + k * bytes_per_pixel;
                                        px.address = addr[31:0];
                                        px.color   = lit ? it.fg_color : it.bg_color;
                                        px.last    = (emitted == total);
                                        awaited_pixels.push_back(px);
                                    end
                                end
                            end
                            nxt = cur + GLYPH_W * bytes_per_pixel;
                            if (nxt % pitch == 0) begin
                                nxt += (GLYPH_H - 1) * pitch;
                                if (nxt + GLYPH_H * pitch >= window_size) nxt = 0;
                            end
                            cursor = nxt[25:0];
                            glyphs_drawn++;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_pixel(logic [btc_pkg::ADDR_W-1:0] address,
                                  logic [btc_pkg::COLOR_W-1:0] color, logic last);
            t_pixel_write want;

            pixels_seen++;
            if (awaited_pixels.size() == 0) begin
                errors++;
                $error("pixel write with nothing expected: address %h color %h last %b",
                       address, color, last);
                return;
            end
            want = awaited_pixels.pop_front();
            if (address !== want.address) begin
                errors++;
                $error("pixel_address mismatch: expected %h, actual %h", want.address, address);
            end
            if (color !== want.color) begin
                errors++;
                $error("pixel_color mismatch: expected %h, actual %h", want.color, color);
            end
            if (last !== want.last) begin
                errors++;
                $error("last_pixel mismatch: expected %b, actual %b", want.last, last);
            end
        endfunction
    endclass

    pixel_write_tracker tracker;

    // Stimulus bookkeeping: which font rows have been loaded, which glyphs
    // are complete and may be drawn, and the register values now in force.
    bit [7:0]           row_mask [256];
    logic [7:0]         drawable[$];
    bit                 idle_en;
    bit [2:0]           stim_bpp;
    bit [14:0]          stim_pitch;
    bit [25:0]          stim_window;
    int                 settings_used;

    bitmap_text_console_renderer i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_char_code    (i_char_code),
        .i_glyph_row    (i_glyph_row),
        .i_font_bits    (i_font_bits),
        .i_fg_color     (i_fg_color),
        .i_bg_color     (i_bg_color),
        .i_cursor_value (i_cursor_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pixel_address(o_pixel_address),
        .o_pixel_color  (o_pixel_color),
        .o_last_pixel   (o_last_pixel)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case a transfer or an expected pixel write never arrives.
    initial begin
        #2_000_000;
        $display("bitmap_text_console_renderer regression: fail");
        $finish;
    end

    // Output back-pressure. Ready drops in random bursts while idling is
    // enabled, with occasional long stretches of no stalls at all.
    initial begin
        i_out_ready <= 1'b1;
        forever begin
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 12)) @(posedge i_clk);
            if (idle_en && $urandom_range(0, 2) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    // Output values sampled here are the ones from before this edge, so the
    // check does not race the block's own register updates.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            tracker.check_pixel(o_pixel_address, o_pixel_color, o_last_pixel);
        end
    end

    // Every field gets random content, so the fields an op does not use
    // still see both values on every bit.
    function automatic t_console_item random_item();
        t_console_item it;
        it.op           = 2'($urandom_range(0, 3));
        it.char_code    = 8'($urandom);
        it.glyph_row    = 3'($urandom);
        it.font_bits    = 8'($urandom);
        it.fg_color     = $urandom;
        it.bg_color     = $urandom;
        it.cursor_value = 26'($urandom);
        return it;
    endfunction

    function automatic logic [31:0] random_color();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Cursor targets lean toward the interesting spots: just before a
    // scanline end, right at the bottom of the window, anywhere, or near 0.
    function automatic logic [25:0] cursor_target();
        longint unsigned p;
        longint unsigned adv;
        longint unsigned v;
        p   = (stim_pitch == 0) ? 1 : stim_pitch;
        adv = GLYPH_W * stim_bpp;
        case ($urandom_range(0, 3))
            0:       v = $urandom_range(1, 40) * p - adv;
            1:       v = stim_window + $urandom_range(0, 2) * p - 9 * p - adv;
            2:       v = $urandom;
            default: v = $urandom_range(0, 4 * 32767);
        endcase
        return v[25:0];
    endfunction

    // Presents one input transfer and waits for it to be taken. Valid is left
    // high afterwards so the next item can follow without a bubble.
    task automatic send_item(t_console_item it);
        bit was_full;
        if (idle_en && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_op           <= it.op;
        i_char_code    <= it.char_code;
        i_glyph_row    <= it.glyph_row;
        i_font_bits    <= it.font_bits;
        i_fg_color     <= it.fg_color;
        i_bg_color     <= it.bg_color;
        i_cursor_value <= it.cursor_value;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_item(it);
        if (it.op == btc_pkg::OP_FONT_LOAD) begin
            was_full = (row_mask[it.char_code] == 8'hFF);
            row_mask[it.char_code][it.glyph_row] = 1'b1;
            // Only glyphs with all rows loaded are ever drawn, and the three
            // control codes never read the font at all.
            if (!was_full && row_mask[it.char_code] == 8'hFF
                && it.char_code != btc_pkg::CHAR_NUL
                && it.char_code != btc_pkg::CHAR_LF
                && it.char_code != btc_pkg::CHAR_CR) begin
                drawable.push_back(it.char_code);
            end
        end
    endtask

    task automatic load_row(logic [7:0] ch, logic [2:0] row, logic [7:0] bits);
        t_console_item it;
        it           = random_item();
        it.op        = btc_pkg::OP_FONT_LOAD;
        it.char_code = ch;
        it.glyph_row = row;
        it.font_bits = bits;
        send_item(it);
    endtask

    task automatic load_glyph(logic [7:0] ch);
        logic [7:0] bits;
        for (int r = 0; r < GLYPH_H; r++) begin
            case ($urandom_range(0, 5))
                0:       bits = 8'h00;
                1:       bits = 8'hFF;
                default: bits = 8'($urandom);
            endcase
            load_row(ch, 3'(r), bits);
        end
    endtask

    task automatic draw(logic [7:0] ch, logic [31:0] fg, logic [31:0] bg);
        t_console_item it;
        it           = random_item();
        it.op        = btc_pkg::OP_DRAW;
        it.char_code = ch;
        it.fg_color  = fg;
        it.bg_color  = bg;
        send_item(it);
    endtask

    task automatic place_cursor(logic [25:0] value);
        t_console_item it;
        it              = random_item();
        it.op           = btc_pkg::OP_SET_CURSOR;
        it.cursor_value = value;
        send_item(it);
    endtask

    task automatic send_ignored_op();
        t_console_item it;
        it    = random_item();
        it.op = OP_UNUSED;
        send_item(it);
    endtask

    // Waits until every predicted pixel write has come out, then gives the
    // block time to finish a draw that produced no writes before anything
    // else (such as a register write) happens.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (tracker.awaited_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes all five registers back to back. Bits above each register's
    // width carry random junk, which the block is expected to drop.
    task automatic write_config(bit so, logic [31:0] base, bit [2:0] bpp, bit [14:0] pitch,
                                bit [25:0] window);
        logic [31:0] data;
        for (int idx = 0; idx < 5; idx++) begin
            data = $urandom;
            case (idx)
                btc_pkg::CFG_SCREEN_ON:  data[0]     = so;
                btc_pkg::CFG_FRAME_BASE: data        = base;
                btc_pkg::CFG_BPP:        data[2:0]   = bpp;
                btc_pkg::CFG_PITCH:      data[14:0]  = pitch;
                default:                 data[25:0]  = window;
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_index <= 3'(idx);
            i_cfg_data  <= data;
            do @(posedge i_clk); while (!o_cfg_ready);
            tracker.note_config(3'(idx), data);
        end
        i_cfg_valid <= 1'b0;
        stim_bpp    = bpp;
        stim_pitch  = pitch;
        stim_window = window;
        settings_used++;
    endtask

    // Random traffic, mostly draws of complete glyphs. NUL and the unused op
    // are mixed in but do not count toward the item budget.
    task automatic random_phase(int budget);
        int counted;
        int pick;
        counted = 0;
        while (counted < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                load_glyph(8'($urandom));
                counted += GLYPH_H;
            end else if (pick < 12) begin
                load_row(8'($urandom), 3'($urandom), 8'($urandom));
                counted++;
            end else if (pick < 26) begin
                place_cursor(cursor_target());
                counted++;
            end else if (pick < 31) begin
                draw(btc_pkg::CHAR_LF, random_color(), random_color());
                counted++;
            end else if (pick < 35) begin
                draw(btc_pkg::CHAR_CR, random_color(), random_color());
                counted++;
            end else if (pick < 37) begin
                draw(btc_pkg::CHAR_NUL, random_color(), random_color());
            end else if (pick < 39) begin
                send_ignored_op();
            end else begin
                draw(drawable[$urandom_range(0, drawable.size() - 1)], random_color(),
                     ($urandom_range(0, 2) == 0) ? 32'h0 : random_color());
                counted++;
            end
        end
    endtask

    initial begin
        logic [7:0] pattern [8];

        tracker        = new();
        settings_used  = 0;
        idle_en        = 1'b1;
        stim_bpp       = btc_pkg::RST_BPP;
        stim_pitch     = btc_pkg::RST_PITCH;
        stim_window    = btc_pkg::RST_WINDOW;
        i_rst_n        <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= '0;
        i_cfg_data     <= '0;
        i_in_valid     <= 1'b0;
        i_op           <= btc_pkg::OP_DRAW;
        i_char_code    <= '0;
        i_glyph_row    <= '0;
        i_font_bits    <= '0;
        i_fg_color     <= '0;
        i_bg_color     <= '0;
        i_cursor_value <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, under the reset register values. One glyph holds the
        // row extremes and alternating bits; another is left blank.
        pattern = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'hAA, 8'h55, 8'hF0, 8'h0F};
        for (int r = 0; r < GLYPH_H; r++) load_row(8'h41, 3'(r), pattern[r]);
        for (int r = 0; r < GLYPH_H; r++) load_row(8'h80, 3'(r), 8'h00);
        // Transparent background, then solid background with a black foreground.
        draw(8'h41, 32'hFFFF_FFFF, 32'h0);
        draw(8'h41, 32'h0, 32'hFFFF_FFFF);
        // A blank glyph on a transparent background writes nothing but still
        // moves the cursor; on a solid background every pixel is written.
        draw(8'h80, $urandom, 32'h0);
        draw(8'h80, 32'h1, 32'h1);
        // The last glyph cell of a scanline drops the cursor one text row.
        place_cursor(26'(btc_pkg::RST_PITCH - GLYPH_W * btc_pkg::RST_BPP));
        draw(8'h41, $urandom, $urandom);
        // The last cell of the last text row wraps the cursor back to zero.
        place_cursor(26'(btc_pkg::RST_WINDOW - GLYPH_H * btc_pkg::RST_PITCH
                         - GLYPH_W * btc_pkg::RST_BPP));
        draw(8'h41, $urandom, $urandom);
        // Cursor arithmetic wraps at the top of the 26-bit range.
        place_cursor(26'h3FF_FFFF);
        draw(8'h41, $urandom, 32'h0);
        place_cursor(26'h12_3456);
        draw(btc_pkg::CHAR_CR, $urandom, $urandom);
        draw(btc_pkg::CHAR_LF, $urandom, $urandom);
        draw(btc_pkg::CHAR_NUL, $urandom, $urandom);
        send_ignored_op();
        draw(8'h80, 32'h0, 32'h8000_0000);
        settle();

        // Register settings, walked through the extremes: tiny pitch and
        // window, zero pitch and window, screen off, odd and zero pixel
        // sizes, a base that makes addresses wrap, and finally the reset
        // shape again with no idling on either side.
        write_config(1'b1, $urandom, 3'd1, 15'd64, 26'd4096);
        random_phase(30);
        settle();
        write_config(1'b1, 32'hFFFF_FF00, 3'd3, 15'd0, 26'd0);
        random_phase(30);
        settle();
        write_config(1'b0, $urandom, 3'd2, 15'd1000, 26'h3FF_FFFF);
        random_phase(20);
        settle();
        write_config(1'b1, 32'hFFFF_FFFF, 3'd7, 15'd32767, 26'h3FF_FFFF);
        random_phase(30);
        settle();
        write_config(1'b1, 32'h0, 3'd0, 15'd256, 26'd65536);
        random_phase(30);
        settle();
        idle_en = 1'b0;
        write_config(1'b1, $urandom, btc_pkg::RST_BPP, btc_pkg::RST_PITCH,
                     btc_pkg::RST_WINDOW);
        random_phase(40);
        settle();

        $display("Run covered %0d drawn glyphs and %0d pixel writes across %0d register settings,",
                 tracker.glyphs_drawn, tracker.pixels_seen, settings_used + 1);
        $display("including cursor moves, control codes, line ends and window wraps.");
        if (tracker.errors == 0) begin
            $display("bitmap_text_console_renderer regression: pass");
        end else begin
            $display("bitmap_text_console_renderer regression: fail");
        end
        $finish;
    end

endmodule
